@@ hdl/debounced_power_toggle_switch_top_macros.svh @@
// Assertion macros for the power toggle switch checker.
`ifndef DEBOUNCED_POWER_TOGGLE_SWITCH_TOP_MACROS_SVH
`define DEBOUNCED_POWER_TOGGLE_SWITCH_TOP_MACROS_SVH

// Check a property while out of reset.
`define DPTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dpts check failed");

// Check a property on every edge, reset included.
`define DPTS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dpts reset check failed");

`endif

@@ hdl/dpts_pkg.sv @@
package dpts_pkg;

  localparam int COUNTER_BITS_DEF = 16;
  localparam int CFG_W            = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int LED_W            = 8;
  localparam int IN_DATA_W        = 8;
  localparam int OUT_DATA_W       = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_RISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_FALL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_STEP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF     = 2'd3;

  localparam logic [CFG_W-1:0] BUTTON_RISE_RST = CFG_W'(65536 / 256);
  localparam logic [CFG_W-1:0] BUTTON_FALL_RST = CFG_W'(65536 / 16);
  localparam logic [CFG_W-1:0] OFF_STEP_RST    = CFG_W'(65536 / 256);
  localparam logic [CFG_W-1:0] HOLDOFF_RST     = CFG_W'(65535);

  localparam logic [LED_W-1:0] LED_FULL = LED_W'(255);
  localparam logic [LED_W-1:0] LED_DARK = LED_W'(0);

  typedef struct packed {
    logic [CFG_W-1:0] button_rise_step;
    logic [CFG_W-1:0] button_fall_step;
    logic [CFG_W-1:0] off_step;
    logic [CFG_W-1:0] holdoff_full;
  } cfg_t;

  typedef struct packed {
    logic [LED_W-1:0] led_blue;
    logic [LED_W-1:0] led_green;
    logic [LED_W-1:0] led_red;
    logic             button_level;
    logic             ssr_enable;
    logic             power_on;
  } res_t;

endpackage

@@ hdl/dpts_cfg.sv @@
module dpts_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dpts_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [dpts_pkg::CFG_W-1:0]     cfg_wdata,
  output dpts_pkg::cfg_t                 cfg
);
  import dpts_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_BUTTON_RISE: cfg_nxt.button_rise_step = cfg_wdata;
        REG_BUTTON_FALL: cfg_nxt.button_fall_step = cfg_wdata;
        REG_OFF_STEP:    cfg_nxt.off_step         = cfg_wdata;
        REG_HOLDOFF:     cfg_nxt.holdoff_full     = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.button_rise_step <= BUTTON_RISE_RST;
      cfg_r.button_fall_step <= BUTTON_FALL_RST;
      cfg_r.off_step         <= OFF_STEP_RST;
      cfg_r.holdoff_full     <= HOLDOFF_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/dpts_core.sv @@
module dpts_core #(
  parameter int COUNTER_BITS = dpts_pkg::COUNTER_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  dpts_pkg::cfg_t cfg,
  input  logic           step,
  input  logic           button_n,
  input  logic           off_n,
  output dpts_pkg::res_t res
);
  import dpts_pkg::*;

  localparam int SW = ((COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W) + 1;
  localparam logic [SW-1:0] CMAX = SW'((65'(1) << COUNTER_BITS) - 65'(1));

  logic [COUNTER_BITS-1:0] bint_r, bint_nxt;
  logic                    deb_r, deb_nxt;
  logic                    pwr_r, pwr_nxt;
  logic [COUNTER_BITS-1:0] hold_r, hold_nxt;
  logic [COUNTER_BITS-1:0] oint_r, oint_nxt;

  logic [SW-1:0]           bint_x, oint_x, rise_x, fall_x, ostep_x, hf_x;
  logic [SW-1:0]           bsum, osum, lim_x;
  logic [SW-1:0]           bdiff, odiff;
  logic [COUNTER_BITS-1:0] lim;
  logic                    pwr_tog;

  always_comb begin
    bint_x  = {{(SW-COUNTER_BITS){1'b0}}, bint_r};
    oint_x  = {{(SW-COUNTER_BITS){1'b0}}, oint_r};
    rise_x  = {{(SW-CFG_W){1'b0}}, cfg.button_rise_step};
    fall_x  = {{(SW-CFG_W){1'b0}}, cfg.button_fall_step};
    ostep_x = {{(SW-CFG_W){1'b0}}, cfg.off_step};
    hf_x    = {{(SW-CFG_W){1'b0}}, cfg.holdoff_full};
    lim_x   = (hf_x > CMAX) ? CMAX : hf_x;
    lim     = lim_x[COUNTER_BITS-1:0];
    bsum    = bint_x + rise_x;
    osum    = oint_x + ostep_x;
    bdiff   = bint_x - fall_x;
    odiff   = oint_x - ostep_x;

    bint_nxt = bint_r;
    deb_nxt  = deb_r;
    if (!button_n) begin
      if (bsum <= CMAX) bint_nxt = bsum[COUNTER_BITS-1:0];
      else deb_nxt = 1'b1;
    end else begin
      if (bint_x >= fall_x) bint_nxt = bdiff[COUNTER_BITS-1:0];
      else deb_nxt = 1'b0;
    end

    pwr_tog = pwr_r ^ (deb_nxt & ~deb_r);

    if (pwr_tog) hold_nxt = (hold_r < lim) ? hold_r + COUNTER_BITS'(1) : hold_r;
    else hold_nxt = '0;

    pwr_nxt  = pwr_tog;
    oint_nxt = '0;
    if (pwr_tog && hold_nxt >= lim) begin
      oint_nxt = oint_r;
      if (!off_n) begin
        if (osum <= CMAX) oint_nxt = osum[COUNTER_BITS-1:0];
        else pwr_nxt = 1'b0;
      end else if (oint_x >= ostep_x) begin
        oint_nxt = odiff[COUNTER_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bint_r <= '0;
      deb_r  <= 1'b0;
      pwr_r  <= 1'b0;
      hold_r <= '0;
      oint_r <= '0;
    end else if (step) begin
      bint_r <= bint_nxt;
      deb_r  <= deb_nxt;
      pwr_r  <= pwr_nxt;
      hold_r <= hold_nxt;
      oint_r <= oint_nxt;
    end
  end

  always_comb begin
    res.power_on     = pwr_nxt;
    res.ssr_enable   = pwr_nxt;
    res.button_level = deb_nxt;
    res.led_red      = pwr_nxt ? LED_DARK : LED_FULL;
    res.led_green    = deb_nxt ? LED_FULL : LED_DARK;
    res.led_blue     = pwr_nxt ? LED_FULL : LED_DARK;
  end

endmodule

@@ hdl/debounced_power_toggle_switch_top.sv @@
// Debounced power toggle switch.
// Input stream: one pin sample per transaction, in_tdata[0] = button_n,
// in_tdata[1] = off_n (both active low). Output stream: one result per
// sample with power_on, ssr_enable, button_level and three LED levels.
// A debounced button press toggles power; after a hold-off of holdoff_full
// samples with power on, a held off pin forces power off.
// Configuration: write cfg_wdata into register cfg_addr while cfg_we is
// high (0 rise step, 1 fall step, 2 off step, 3 hold-off length), only
// while the block is idle.
// Data path: an accepted sample goes through the input register, then the update
// logic into the output register; a stalled receiver holds it in the input stage.
// Throughput: one sample per cycle while the receiver does not stall, set by the
// state update between the input register and the output register.
// Reset: all filters and the hold-off counter clear, power is off, both
// stages empty, registers return to their defaults.
// When the receiver stalls, the result holds and the input stage fills;
// in_tready drops once both are occupied.
module debounced_power_toggle_switch_top #(
  parameter int COUNTER_BITS = dpts_pkg::COUNTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dpts_pkg::IN_DATA_W-1:0]  in_tdata,   // button_n, off_n
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // power_on, ssr_enable, button_level, led_red[7:0], led_green[7:0], led_blue[7:0]
  output logic [dpts_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [dpts_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [dpts_pkg::CFG_W-1:0]      cfg_wdata
);
  import dpts_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_r;

  logic in_valid_r, in_valid_nxt;
  logic button_n_r, off_n_r;
  logic out_valid_r, out_valid_nxt;
  logic advance, step;

  assign advance   = ~out_valid_r | out_tready;
  assign in_tready = ~in_valid_r | advance;
  assign step      = in_valid_r & advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tready) in_valid_nxt = in_tvalid;
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = in_valid_r;
  end

  dpts_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dpts_core #(.COUNTER_BITS(COUNTER_BITS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .step     (step),
    .button_n (button_n_r),
    .off_n    (off_n_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      button_n_r <= in_tdata[0];
      off_n_r    <= in_tdata[1];
    end
    if (step) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, res_r};

endmodule

@@ hdl/dpts_checker.sv @@
`include "debounced_power_toggle_switch_top_macros.svh"

module dpts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        cfg_we,
  input logic [1:0]  cfg_addr,
  input logic [15:0] cfg_wdata
);

  logic leds_ok;

  assign leds_ok = (out_tdata[10:3] == {8{~out_tdata[0]}}) &&
                   (out_tdata[18:11] == {8{out_tdata[2]}}) &&
                   (out_tdata[26:19] == {8{out_tdata[0]}});

  `DPTS_ASSERT(a_ssr_follows_power, out_tvalid |-> (out_tdata[1] == out_tdata[0]))
  `DPTS_ASSERT(a_leds_match, out_tvalid |-> leds_ok)
  `DPTS_ASSERT(a_stall_holds, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
  `DPTS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid)

endmodule

bind debounced_power_toggle_switch_top dpts_checker u_dpts_checker (.*);
